[hw/rtl/owrs_pkg.sv]
// Shared types and constants of the 1-Wire ROM search engine.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package owrs_pkg;

  // number of bytes in a device ID, default of the top-level parameter
  localparam int ROM_BYTES_DEF = 8;

  // widths of the result fields
  localparam int ID_W     = 64;
  localparam int POS_W    = 7;
  localparam int FAM_W    = 4;
  localparam int STATUS_W = 3;
  localparam int BYTE_W   = 8;

  // zero choices below this position fall inside the family byte
  localparam int FAM_LIMIT = 9;

  // command byte after reset
  localparam logic [BYTE_W-1:0] SEARCH_CMD_RST = 8'hF0;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [FAM_W-1:0]    fam_t;

  // input item kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BITS  = 1'b1;

  // result status codes
  localparam status_t ST_SEND_CMD = 3'd0;
  localparam status_t ST_WRITE    = 3'd1;
  localparam status_t ST_FINAL    = 3'd2;
  localparam status_t ST_NONE     = 3'd3;
  localparam status_t ST_IGNORED  = 3'd4;

endpackage

`default_nettype wire

[hw/rtl/owrs_if.sv]
// Valid/ready channel interfaces of the 1-Wire ROM search engine.
// Depends on owrs_pkg for field widths and types.
`default_nettype none

interface owrs_in_if
  import owrs_pkg::*;
();
  logic valid;
  logic ready;
  logic cmd;
  logic restart;
  logic line_after_reset;
  logic id_bit;
  logic complement_bit;

  modport source (output valid, cmd, restart, line_after_reset, id_bit, complement_bit,
                  input ready);
  modport sink   (input valid, cmd, restart, line_after_reset, id_bit, complement_bit,
                  output ready);
endinterface

interface owrs_out_if
  import owrs_pkg::*;
();
  logic              valid;
  logic              ready;
  status_t           status;
  logic              write_bit;
  logic [BYTE_W-1:0] command_byte;
  logic              found;
  logic [ID_W-1:0]   rom_id;
  logic              last_device;
  fam_t              family_discrepancy;

  modport source (output valid, status, write_bit, command_byte, found, rom_id,
                  last_device, family_discrepancy,
                  input ready);
  modport sink   (input valid, status, write_bit, command_byte, found, rom_id,
                  last_device, family_discrepancy,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/one_wire_rom_search.sv]
// 1-Wire ROM search engine top level (discrepancy algorithm, one bit pair per beat).
// Depends on owrs_pkg and the channel interfaces in owrs_if.sv.
//
// Each input beat is either a start (after a bus reset, with the sampled presence
// level) or one read bit pair; every beat yields exactly one result beat. A beat is
// taken into an input register, processed against the search state once the output
// register is free, and the result is held in an output register until taken.
// Throughput is one beat per clock cycle while result beats are taken without stall.
// ROM_BYTES sets the ID length that closes a pass. search_command may be written only
// while idle.
`default_nettype none

module one_wire_rom_search
  import owrs_pkg::*;
#(
  parameter int ROM_BYTES = ROM_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  owrs_in_if.sink                in_ch,
  owrs_out_if.source             out_ch
);

  localparam int ROM_BITS = ROM_BYTES * 8;
  localparam int IDX_W    = $clog2(ROM_BITS);

  // configuration
  logic [BYTE_W-1:0] search_cmd_r;

  // input register
  logic s1_v_r;
  logic s1_cmd_r, s1_restart_r, s1_line_r, s1_id_r, s1_cmp_r;

  // search state
  logic [ROM_BITS-1:0] rom_bits_r, rom_bits_nxt;
  pos_t                last_disc_r, last_disc_nxt;
  pos_t                recent_zero_r, recent_zero_nxt;
  pos_t                bit_pos_r, bit_pos_nxt;
  logic                last_dev_r, last_dev_nxt;
  fam_t                fam_zero_r, fam_zero_nxt;
  logic                searching_r, searching_nxt;

  // result register
  logic              out_v_r;
  status_t           status_r, status_nxt;
  logic              wbit_r, wbit_nxt;
  logic [BYTE_W-1:0] cbyte_r, cbyte_nxt;
  logic              found_r, found_nxt;
  logic [ID_W-1:0]   rom_id_r;
  logic              lastdev_r, lastdev_nxt;
  fam_t              fam_out_r;

  logic             out_free, proc;
  logic [IDX_W-1:0] bit_idx;
  logic             dir;
  pos_t             zero_pos;

  // handshake: output register frees when taken, input register drains into it
  assign out_free     = !out_v_r || out_ch.ready;
  assign proc         = s1_v_r && out_free;
  assign in_ch.ready  = !s1_v_r || out_free;
  assign bit_idx      = IDX_W'(bit_pos_r - pos_t'(1));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_cmd_r <= SEARCH_CMD_RST;
    end else if (cfg_we) begin
      search_cmd_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r     <= in_ch.cmd;
      s1_restart_r <= in_ch.restart;
      s1_line_r    <= in_ch.line_after_reset;
      s1_id_r      <= in_ch.id_bit;
      s1_cmp_r     <= in_ch.complement_bit;
    end
  end

  // one search step
  always_comb begin
    rom_bits_nxt    = rom_bits_r;
    last_disc_nxt   = last_disc_r;
    recent_zero_nxt = recent_zero_r;
    bit_pos_nxt     = bit_pos_r;
    last_dev_nxt    = last_dev_r;
    fam_zero_nxt    = fam_zero_r;
    searching_nxt   = searching_r;
    status_nxt      = ST_IGNORED;
    wbit_nxt        = 1'b0;
    cbyte_nxt       = '0;
    found_nxt       = 1'b0;
    lastdev_nxt     = 1'b0;
    dir             = 1'b0;
    zero_pos        = recent_zero_r;

    if (s1_cmd_r == CMD_START) begin
      // start of a pass after bus reset
      if (s1_restart_r) begin
        last_disc_nxt = '0;
        last_dev_nxt  = 1'b0;
        fam_zero_nxt  = '0;
      end
      searching_nxt = 1'b0;
      if (last_dev_nxt || s1_line_r) begin
        last_disc_nxt = '0;
        last_dev_nxt  = 1'b0;
        fam_zero_nxt  = '0;
        status_nxt    = ST_NONE;
      end else begin
        searching_nxt   = 1'b1;
        bit_pos_nxt     = pos_t'(1);
        recent_zero_nxt = '0;
        cbyte_nxt       = search_cmd_r;
        status_nxt      = ST_SEND_CMD;
      end
    end else if (!searching_r) begin
      status_nxt = ST_IGNORED;
    end else if (s1_id_r && s1_cmp_r) begin
      // nobody answered
      searching_nxt = 1'b0;
      last_disc_nxt = '0;
      last_dev_nxt  = 1'b0;
      fam_zero_nxt  = '0;
      status_nxt    = ST_NONE;
    end else begin
      // choose direction
      if (s1_id_r != s1_cmp_r) begin
        dir = s1_id_r;
      end else begin
        if (bit_pos_r < last_disc_r) begin
          dir = rom_bits_r[bit_idx];
        end else begin
          dir = (bit_pos_r == last_disc_r);
        end
        if (!dir) begin
          zero_pos = bit_pos_r;
          if (bit_pos_r < pos_t'(FAM_LIMIT)) begin
            fam_zero_nxt = bit_pos_r[FAM_W-1:0];
          end
        end
      end
      recent_zero_nxt       = zero_pos;
      rom_bits_nxt[bit_idx] = dir;
      wbit_nxt              = dir;
      bit_pos_nxt           = bit_pos_r + pos_t'(1);

      // close the pass after the last ID bit
      if (bit_pos_r >= pos_t'(ROM_BITS)) begin
        searching_nxt = 1'b0;
        last_disc_nxt = zero_pos;
        if (zero_pos == '0) begin
          last_dev_nxt = 1'b1;
        end
        if (rom_bits_nxt[7:0] == 8'h00) begin
          last_disc_nxt = '0;
          last_dev_nxt  = 1'b0;
          fam_zero_nxt  = '0;
        end else begin
          found_nxt   = 1'b1;
          lastdev_nxt = last_dev_nxt;
        end
        status_nxt = ST_FINAL;
      end else begin
        status_nxt = ST_WRITE;
      end
    end
  end

  // search state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bits_r    <= '0;
      last_disc_r   <= '0;
      recent_zero_r <= '0;
      bit_pos_r     <= pos_t'(1);
      last_dev_r    <= 1'b0;
      fam_zero_r    <= '0;
      searching_r   <= 1'b0;
    end else if (proc) begin
      rom_bits_r    <= rom_bits_nxt;
      last_disc_r   <= last_disc_nxt;
      recent_zero_r <= recent_zero_nxt;
      bit_pos_r     <= bit_pos_nxt;
      last_dev_r    <= last_dev_nxt;
      fam_zero_r    <= fam_zero_nxt;
      searching_r   <= searching_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      status_r  <= status_nxt;
      wbit_r    <= wbit_nxt;
      cbyte_r   <= cbyte_nxt;
      found_r   <= found_nxt;
      rom_id_r  <= ID_W'(rom_bits_nxt);
      lastdev_r <= lastdev_nxt;
      fam_out_r <= fam_zero_nxt;
    end
  end

  // result beat
  assign out_ch.valid              = out_v_r;
  assign out_ch.status             = status_r;
  assign out_ch.write_bit          = wbit_r;
  assign out_ch.command_byte       = cbyte_r;
  assign out_ch.found              = found_r;
  assign out_ch.rom_id             = rom_id_r;
  assign out_ch.last_device        = lastdev_r;
  assign out_ch.family_discrepancy = fam_out_r;

endmodule

`default_nettype wire

[tb/tb_one_wire_rom_search.sv]
// Self-checking testbench for the 1-Wire ROM search engine: directed beats, then random
// enumeration sessions against a modeled bus of devices, checked by a built-in predictor.
// Depends on owrs_pkg, owrs_if.sv and one_wire_rom_search.sv.
`timescale 1ns / 1ps

module tb_one_wire_rom_search
  import owrs_pkg::*;
;

  localparam int ROM_BITS    = ROM_BYTES_DEF * 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_BEATS = 150;

  typedef struct packed {
    logic cmd;
    logic restart;
    logic line_after_reset;
    logic id_bit;
    logic complement_bit;
  } search_beat_t;

  typedef struct packed {
    status_t           status;
    logic              write_bit;
    logic [BYTE_W-1:0] command_byte;
    logic              found;
    logic [ID_W-1:0]   rom_id;
    logic              last_device;
    fam_t              family_discrepancy;
  } search_result_t;

  typedef struct {
    logic [ID_W-1:0]   rom;
    pos_t              last_disc;
    pos_t              recent_zero;
    pos_t              bit_pos;
    logic              last_dev;
    fam_t              fam_zero;
    logic              searching;
    logic [BYTE_W-1:0] search_cmd;
  } search_state_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  owrs_in_if  in_ch ();
  owrs_out_if out_ch ();

  one_wire_rom_search #(.ROM_BYTES(ROM_BYTES_DEF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // bus-side copy drives generation, engine-side copy predicts accepted beats
  search_state_t   bus_state;
  search_state_t   engine_state;
  search_beat_t    pending_beats[$];
  search_result_t  expected_results[$];
  logic [ID_W-1:0] bus_ids[$];

  int send_idle_pct;
  int recv_stall_pct;
  int beats_queued;
  int beats_taken;
  int results_checked;
  int ids_found;
  int n_mismatch;
  int status_count [0:4];
  int quiet_cycles;
  int hold_left;
  logic hold_arm;
  logic hold_fired;

  // search state after reset
  function automatic search_state_t search_after_reset();
    search_state_t s;
    s.rom         = '0;
    s.last_disc   = '0;
    s.recent_zero = '0;
    s.bit_pos     = pos_t'(1);
    s.last_dev    = 1'b0;
    s.fam_zero    = '0;
    s.searching   = 1'b0;
    s.search_cmd  = SEARCH_CMD_RST;
    return s;
  endfunction

  function automatic void forget_search(inout search_state_t s);
    s.last_disc = '0;
    s.last_dev  = 1'b0;
    s.fam_zero  = '0;
  endfunction

  // one beat of the discrepancy search: updates state, returns the result beat
  function automatic search_result_t rom_search_step(inout search_state_t s,
                                                     input search_beat_t b);
    search_result_t r;
    pos_t           pos;
    logic [5:0]     idx;
    logic           dir;
    r = '0;
    if (b.cmd == CMD_START) begin
      if (b.restart) forget_search(s);
      s.searching = 1'b0;
      if (s.last_dev || b.line_after_reset) begin
        forget_search(s);
        r.status = ST_NONE;
      end else begin
        s.searching    = 1'b1;
        s.bit_pos      = pos_t'(1);
        s.recent_zero  = '0;
        r.command_byte = s.search_cmd;
        r.status       = ST_SEND_CMD;
      end
    end else if (!s.searching) begin
      r.status = ST_IGNORED;
    end else if (b.id_bit && b.complement_bit) begin
      // nobody answered
      s.searching = 1'b0;
      forget_search(s);
      r.status = ST_NONE;
    end else begin
      pos = s.bit_pos;
      idx = pos[5:0] - 6'd1;
      if (b.id_bit != b.complement_bit) begin
        dir = b.id_bit;
      end else begin
        // discrepancy: follow the previous path below the last one, take 1 at it
        if (pos < s.last_disc) dir = s.rom[idx];
        else dir = (pos == s.last_disc);
        if (!dir) begin
          s.recent_zero = pos;
          if (pos < FAM_LIMIT) s.fam_zero = pos[FAM_W-1:0];
        end
      end
      s.rom[idx]  = dir;
      r.write_bit = dir;
      s.bit_pos   = pos + pos_t'(1);
      if (pos >= ROM_BITS) begin
        // pass complete
        s.searching = 1'b0;
        s.last_disc = s.recent_zero;
        if (s.last_disc == '0) s.last_dev = 1'b1;
        if (s.rom[7:0] == '0) begin
          forget_search(s);
        end else begin
          r.found       = 1'b1;
          r.last_device = s.last_dev;
        end
        r.status = ST_FINAL;
      end else begin
        r.status = ST_WRITE;
      end
    end
    r.rom_id             = s.rom;
    r.family_discrepancy = s.fam_zero;
    return r;
  endfunction

  function automatic search_result_t queue_beat(search_beat_t b);
    pending_beats.push_back(b);
    beats_queued++;
    return rom_search_step(bus_state, b);
  endfunction

  // one search pass answered by the modeled bus; cut_at stops the pass early,
  // drop_at makes every device go silent from that bit on
  function automatic search_result_t push_pass(logic rs, int cut_at, int drop_at);
    search_beat_t    b;
    search_result_t  r;
    logic [ID_W-1:0] alive[$];
    logic [ID_W-1:0] keep[$];
    b.cmd              = CMD_START;
    b.restart          = rs;
    b.line_after_reset = (bus_ids.size() == 0) ^ ($urandom_range(19) == 0);
    b.id_bit           = $urandom_range(1);
    b.complement_bit   = $urandom_range(1);
    r = queue_beat(b);
    if (r.status != ST_SEND_CMD) return r;
    alive = bus_ids;
    for (int k = 0; k < ROM_BITS && k != cut_at; k++) begin
      if (k == drop_at) alive.delete();
      b.cmd              = CMD_BITS;
      b.restart          = $urandom_range(1);
      b.line_after_reset = $urandom_range(1);
      b.id_bit           = 1'b1;
      b.complement_bit   = 1'b1;
      // open-drain wired-and of every device still selected
      foreach (alive[i]) begin
        b.id_bit         &= alive[i][k];
        b.complement_bit &= ~alive[i][k];
      end
      r = queue_beat(b);
      if (r.status != ST_WRITE) return r;
      keep.delete();
      foreach (alive[i]) if (alive[i][k] == r.write_bit) keep.push_back(alive[i]);
      alive = keep;
    end
    return r;
  endfunction

  // new random bus, then enumerate it pass by pass
  function automatic void run_session();
    logic [ID_W-1:0] base;
    logic [ID_W-1:0] id;
    int              ndev;
    logic            rs;
    search_result_t  r;
    bus_ids.delete();
    ndev = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
    base = {$urandom, $urandom};
    repeat (ndev) begin
      id = base;
      if ($urandom_range(3) == 0) begin
        id = {$urandom, $urandom};
      end else begin
        // near neighbors, often differing inside the family byte
        repeat ($urandom_range(1, 3))
          id[$urandom_range(1) ? $urandom_range(7) : $urandom_range(ROM_BITS - 1)] ^= 1'b1;
      end
      if ($urandom_range(5) == 0) id[7:0] = '0;
      bus_ids.push_back(id);
    end
    for (int p = 0; p < 8; p++) begin
      rs = (p == 0) || ($urandom_range(19) == 0);
      r = push_pass(rs,
                    ($urandom_range(9) == 0) ? $urandom_range(ROM_BITS - 1) : -1,
                    ($urandom_range(14) == 0) ? $urandom_range(ROM_BITS - 1) : -1);
      if (bus_state.last_dev) begin
        // start once more after the last device
        void'(queue_beat({CMD_START, 1'b0, 1'b0, 1'(($urandom_range(1))),
                          1'(($urandom_range(1)))}));
        break;
      end
      if (r.status == ST_FINAL && !r.found) break;
      if ($urandom_range(7) == 0)
        repeat ($urandom_range(1, 3)) void'(queue_beat(5'($urandom)));
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_search_cmd(input logic [BYTE_W-1:0] v);
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bus_state.search_cmd    = v;
    engine_state.search_cmd = v;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input driver: holds a beat until taken, predicts on acceptance
  always @(posedge clk) begin : in_driver
    logic took;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        expected_results.push_back(rom_search_step(engine_state, pending_beats.pop_front()));
        beats_taken++;
      end
      if (!in_ch.valid || took) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid            <= 1'b1;
          in_ch.cmd              <= pending_beats[0].cmd;
          in_ch.restart          <= pending_beats[0].restart;
          in_ch.line_after_reset <= pending_beats[0].line_after_reset;
          in_ch.id_bit           <= pending_beats[0].id_bit;
          in_ch.complement_bit   <= pending_beats[0].complement_bit;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each result beat with the oldest expectation
  always @(posedge clk) begin : out_monitor
    search_result_t seen;
    search_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_fired   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.status             = out_ch.status;
        seen.write_bit          = out_ch.write_bit;
        seen.command_byte       = out_ch.command_byte;
        seen.found              = out_ch.found;
        seen.rom_id             = out_ch.rom_id;
        seen.last_device        = out_ch.last_device;
        seen.family_discrepancy = out_ch.family_discrepancy;
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result beat with nothing expected: status %0d rom_id %h",
                     seen.status, seen.rom_id);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          status_count[want.status]++;
          if (want.status == ST_FINAL && want.found) ids_found++;
          if (seen !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch (exp/got): status %0d/%0d write_bit %0b/%0b cmd %h/%h",
                       want.status, seen.status, want.write_bit, seen.write_bit,
                       want.command_byte, seen.command_byte);
              $display("  found %0b/%0b rom_id %h/%h last %0b/%0b family %0d/%0d",
                       want.found, seen.found, want.rom_id, seen.rom_id,
                       want.last_device, seen.last_device,
                       want.family_discrepancy, seen.family_discrepancy);
            end
          end
        end
      end
      // ready: one long hold-off when armed, else random stalls
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_arm && !hold_fired && out_ch.valid) begin
        hold_left    <= LONG_HOLD;
        hold_fired   <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and phase control
  initial begin : stimulus
    int                target;
    logic [BYTE_W-1:0] cmd_vals[4];
    int                idle_pct[4];
    int                stall_pct[4];
    idle_pct  = '{0, 74, 0, 14};
    stall_pct = '{0, 0, 74, 14};
    cmd_vals  = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.cmd              = CMD_START;
    in_ch.restart          = 1'b0;
    in_ch.line_after_reset = 1'b0;
    in_ch.id_bit           = 1'b0;
    in_ch.complement_bit   = 1'b0;
    out_ch.ready           = 1'b0;
    hold_arm               = 1'b0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    bus_state              = search_after_reset();
    engine_state           = search_after_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle pairs, no presence, start mid-pass, silent bus, restarts
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b1, 1'b1}));
    void'(queue_beat({CMD_BITS,  1'b1, 1'b1, 1'b0, 1'b0}));
    void'(queue_beat({CMD_START, 1'b0, 1'b1, 1'b0, 1'b0}));
    void'(queue_beat({CMD_START, 1'b1, 1'b0, 1'b1, 1'b1}));
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b1, 1'b0}));
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b0, 1'b1}));
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b0, 1'b0}));
    void'(queue_beat({CMD_BITS,  1'b1, 1'b1, 1'b0, 1'b0}));
    void'(queue_beat({CMD_START, 1'b0, 1'b0, 1'b0, 1'b0}));
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b0, 1'b0}));
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b1, 1'b1}));
    void'(queue_beat({CMD_BITS,  1'b0, 1'b0, 1'b0, 1'b1}));
    void'(queue_beat({CMD_START, 1'b1, 1'b1, 1'b1, 1'b0}));
    void'(queue_beat({CMD_START, 1'b0, 1'b0, 1'b0, 1'b1}));
    void'(queue_beat({CMD_BITS,  1'b1, 1'b0, 1'b1, 1'b1}));
    wait_drained();

    // random enumeration phases, each with its own command byte, send idling and receive stalling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      write_search_cmd(cmd_vals[ph]);
      if (ph == 0) hold_arm = 1'b1;
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) run_session();
      wait_drained();
    end
    repeat (8) @(posedge clk);

    $display("covered %0d input beats, %0d results: %0d command, %0d bit, %0d final",
             beats_taken, results_checked, status_count[ST_SEND_CMD],
             status_count[ST_WRITE], status_count[ST_FINAL]);
    $display("  %0d ids found, %0d ended without device, %0d ignored, %0d mismatches",
             ids_found, status_count[ST_NONE], status_count[ST_IGNORED], n_mismatch);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
